### design/alm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and status types of the audio level meter.
package alm_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W  = 10;
    localparam int MAG_W     = 10;
    localparam int LEVEL_W   = 10;
    localparam int AVG_W     = 11;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;
    // top_offset times level difference
    localparam int NUM_W     = CFG_W + LEVEL_W;

    // Default depth of the magnitude history
    localparam int HISTORY_DEPTH = 6;

    // Arithmetic constants
    localparam int MIDPOINT    = 512;
    localparam int LEVEL_KEEP  = 7;
    localparam int LEVEL_SHIFT = 3;
    localparam int BOUND_KEEP  = 63;
    localparam int BOUND_SHIFT = 6;
    localparam int MIN_HEIGHT  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_RATE   = 3'd4;

    // Reset values
    localparam logic [CFG_W-1:0]   DC_OFFSET_RST   = 8'd0;
    localparam logic [CFG_W-1:0]   NOISE_FLOOR_RST = 8'd20;
    localparam logic [CFG_W-1:0]   TOP_OFFSET_RST  = 8'd18;
    localparam logic [CFG_W-1:0]   LED_COUNT_RST   = 8'd16;
    localparam logic [CFG_W-1:0]   FALL_RATE_RST   = 8'd6;
    localparam logic [LEVEL_W-1:0] LEVEL_RST       = 10'd10;
    localparam logic [AVG_W-1:0]   MIN_AVG_RST     = 11'd0;
    localparam logic [AVG_W-1:0]   MAX_AVG_RST     = 11'd512;

    // History scan status: min and max are final once busy drops
    typedef struct packed {
        logic             busy;
        logic [MAG_W-1:0] mn;
        logic [MAG_W-1:0] mx;
    } scan_res_t;

    // Serial scale unit status: quotient is final once busy drops
    typedef struct packed {
        logic             busy;
        logic [NUM_W-1:0] quot;
    } scale_res_t;

endpackage

### design/alm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module alm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/alm_hist.sv
`timescale 1ns / 1ps
// Magnitude history: circular write and a one-entry-per-cycle min/max scan.
module alm_hist #(
    parameter int DEPTH = alm_pkg::HISTORY_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [alm_pkg::MAG_W-1:0]    mag,
    output alm_pkg::scan_res_t           res
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [IDX_W-1:0]          wr_idx_reg;
    logic [CNT_W-1:0]          fill_reg;
    logic                      scan_reg;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic                      pend_reg;
    logic                      pend_first_reg;
    logic                      pend_written_reg;
    logic [alm_pkg::MAG_W-1:0] mn_reg;
    logic [alm_pkg::MAG_W-1:0] mx_reg;
    logic [alm_pkg::MAG_W-1:0] rd_data;
    logic [alm_pkg::MAG_W-1:0] entry;

    alm_ram #(
        .WIDTH (alm_pkg::MAG_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (start),
        .waddr (wr_idx_reg),
        .wdata (mag),
        .raddr (rd_idx_reg),
        .rdata (rd_data)
    );

    // Entries beyond the fill count were never written and read as zero
    assign entry = pend_written_reg ? rd_data : '0;

    // Write pointer, fill count and scan sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg       <= '0;
            fill_reg         <= '0;
            scan_reg         <= 1'b0;
            rd_idx_reg       <= '0;
            pend_reg         <= 1'b0;
            pend_first_reg   <= 1'b0;
            pend_written_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                wr_idx_reg <= (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + IDX_W'(1);
                if (fill_reg != FULL_CNT)
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end

            if (start)
            begin
                scan_reg   <= 1'b1;
                rd_idx_reg <= '0;
            end
            else if (scan_reg)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                if (rd_idx_reg == LAST_IDX)
                begin
                    scan_reg <= 1'b0;
                end
            end

            // Tags that follow each read through the RAM output register
            pend_reg         <= scan_reg;
            pend_first_reg   <= (rd_idx_reg == '0);
            pend_written_reg <= (CNT_W'(rd_idx_reg) < fill_reg);
        end
    end

    // Running minimum and maximum
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            if (pend_first_reg || (entry < mn_reg))
            begin
                mn_reg <= entry;
            end
            if (pend_first_reg || (entry > mx_reg))
            begin
                mx_reg <= entry;
            end
        end
    end

    assign res.busy = scan_reg | pend_reg;
    assign res.mn   = mn_reg;
    assign res.mx   = mx_reg;

endmodule

### design/alm_scale.sv
`timescale 1ns / 1ps
// Bit-serial scale unit: shift-add multiply, then restoring divide.
module alm_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [alm_pkg::CFG_W-1:0]   factor,
    input  logic [alm_pkg::LEVEL_W-1:0] diff,
    input  logic [alm_pkg::AVG_W-1:0]   span,
    output alm_pkg::scale_res_t         res
);

    localparam int NUM_W = alm_pkg::NUM_W;
    localparam int AVG_W = alm_pkg::AVG_W;
    localparam int CFG_W = alm_pkg::CFG_W;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(CFG_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_MUL  = 3'b010,
        PH_DIV  = 3'b100
    } phase_t;

    phase_t                      phase_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CFG_W-1:0]            mplier_reg;
    logic [alm_pkg::LEVEL_W-1:0] mcand_reg;
    logic [AVG_W-1:0]            divisor_reg;
    logic [NUM_W-1:0]            acc_reg;
    logic [AVG_W-1:0]            rem_reg;

    logic [NUM_W-1:0]            mul_acc;
    logic [AVG_W:0]              rem_sh;
    logic [AVG_W:0]              rem_sub;
    logic                        rem_ge;

    // One multiplier bit, MSB first
    assign mul_acc = {acc_reg[NUM_W-2:0], 1'b0}
                   + (mplier_reg[CFG_W-1] ? NUM_W'(mcand_reg) : '0);

    // One quotient bit; the dividend shifts out of acc as quotient shifts in
    assign rem_sh  = {rem_reg, acc_reg[NUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, divisor_reg};
    assign rem_sub = rem_sh - {1'b0, divisor_reg};

    // Phase and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_MUL;
                        cnt_reg   <= '0;
                    end
                end
                PH_MUL:
                begin
                    if (cnt_reg == MUL_LAST)
                    begin
                        phase_reg <= PH_DIV;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                PH_DIV:
                begin
                    if (cnt_reg == DIV_LAST)
                    begin
                        phase_reg <= PH_IDLE;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                    cnt_reg   <= '0;
                end
            endcase
        end
    end

    // Operand and accumulator shift registers
    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    mplier_reg  <= factor;
                    mcand_reg   <= diff;
                    divisor_reg <= span;
                    acc_reg     <= '0;
                    rem_reg     <= '0;
                end
            end
            PH_MUL:
            begin
                acc_reg    <= mul_acc;
                mplier_reg <= {mplier_reg[CFG_W-2:0], 1'b0};
            end
            PH_DIV:
            begin
                rem_reg <= rem_ge ? rem_sub[AVG_W-1:0] : rem_sh[AVG_W-1:0];
                acc_reg <= {acc_reg[NUM_W-2:0], rem_ge};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign res.busy = (phase_reg != PH_IDLE);
    assign res.quot = acc_reg;

endmodule

### design/audio_level_meter_autorange_core.sv
`timescale 1ns / 1ps
// Top level of the audio level meter with auto-ranged bar and falling peak dot.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_stall  mic_sample
//   output    out        out_valid/ out_stall bar_height, peak_position,
//                                             peak_visible, smoothed_level
//   config    in         cfg_we               cfg_index, cfg_data
//
// A new sample is taken only in the idle state, after the previous one has finished.
// Throughput is bounded by the serial scale unit (8 multiply steps, 18 divide
// steps) and by the history scan, which reads one entry per cycle.
// Reset restores the register defaults and the level, bounds and peak reset values.
// The next sample is taken while a finished result waits in the output register;
// a result only stalls the core when the following one is ready to be written.
module audio_level_meter_autorange_core #(
    parameter int HISTORY_DEPTH = alm_pkg::HISTORY_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [alm_pkg::SAMPLE_W-1:0]   mic_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [alm_pkg::CFG_W-1:0]      bar_height,
    output logic [alm_pkg::CFG_W-1:0]      peak_position,
    output logic                           peak_visible,
    output logic [alm_pkg::LEVEL_W-1:0]    smoothed_level,
    input  logic                           cfg_we,
    input  logic [alm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [alm_pkg::CFG_W-1:0]      cfg_data
);

    localparam int SAMPLE_W = alm_pkg::SAMPLE_W;
    localparam int MAG_W    = alm_pkg::MAG_W;
    localparam int LEVEL_W  = alm_pkg::LEVEL_W;
    localparam int AVG_W    = alm_pkg::AVG_W;
    localparam int CFG_W    = alm_pkg::CFG_W;
    localparam int NUM_W    = alm_pkg::NUM_W;
    localparam int CENT_W   = SAMPLE_W + 2;
    localparam int LSUM_W   = LEVEL_W + alm_pkg::LEVEL_SHIFT;
    localparam int BSUM_W   = AVG_W + alm_pkg::BOUND_SHIFT;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAG   = 6'b000010,
        ST_LEVEL = 6'b000100,
        ST_START = 6'b001000,
        ST_CALC  = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t               state_reg;
    state_t               state_next;

    // Configuration registers
    logic [CFG_W-1:0]     dc_offset_reg;
    logic [CFG_W-1:0]     noise_floor_reg;
    logic [CFG_W-1:0]     top_offset_reg;
    logic [CFG_W-1:0]     led_count_reg;
    logic [CFG_W-1:0]     fall_rate_reg;

    // Persistent meter state
    logic [LEVEL_W-1:0]   level_reg;
    logic [AVG_W-1:0]     min_avg_reg;
    logic [AVG_W-1:0]     max_avg_reg;
    logic [CFG_W-1:0]     peak_reg;
    logic [CFG_W-1:0]     fall_cnt_reg;

    // Per-sample working registers
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic                 span_pos_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [MAG_W-1:0]     mn_hold_reg;
    logic [AVG_W-1:0]     mx_hold_reg;

    // Output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CFG_W-1:0]     bar_height_reg;
    logic [CFG_W-1:0]     peak_position_reg;
    logic                 peak_visible_reg;
    logic [LEVEL_W-1:0]   smoothed_level_reg;

    // Datapath nets
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 out_free;
    logic                 calc_done;
    logic                 fin_fire;
    logic [CENT_W-1:0]    centred;
    logic [CENT_W-1:0]    centred_abs;
    logic [MAG_W-1:0]     abs_low;
    logic [MAG_W-1:0]     mag_next;
    logic [LSUM_W-1:0]    level_sum;
    logic [LEVEL_W-1:0]   level_next;
    logic [AVG_W-1:0]     level_ext;
    logic [AVG_W-1:0]     diff_full;
    logic [AVG_W-1:0]     span;
    logic [NUM_W-1:0]     height_raw;
    logic [CFG_W-1:0]     height_next;
    logic [MAG_W-1:0]     scan_span;
    logic [AVG_W-1:0]     mx_adj;
    logic [CFG_W-1:0]     peak_up;
    logic [CFG_W-1:0]     fall_inc;
    logic                 fall_drop;
    logic [CFG_W-1:0]     peak_next;
    logic [CFG_W-1:0]     fall_cnt_next;
    logic [BSUM_W-1:0]    min_sum;
    logic [BSUM_W-1:0]    max_sum;
    logic [AVG_W-1:0]     min_avg_next;
    logic [AVG_W-1:0]     max_avg_next;

    alm_pkg::scan_res_t   scan;
    alm_pkg::scale_res_t  scale;

    // History store and min/max scan, started with each new magnitude
    alm_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_LEVEL),
        .mag   (mag_reg),
        .res   (scan)
    );

    // Serial top_offset * (level - min) / span
    alm_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == ST_START),
        .factor (top_offset_reg),
        .diff   (diff_full[LEVEL_W-1:0]),
        .span   (span),
        .res    (scale)
    );

    // Handshakes
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && (state_reg == ST_IDLE);
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign calc_done = !scale.busy && !scan.busy;
    assign fin_fire  = (state_reg == ST_FIN) && out_free;

    // Magnitude: center on midpoint plus offset, rectify, remove noise floor
    always_comb
    begin
        centred     = {2'b00, sample_reg} - CENT_W'(alm_pkg::MIDPOINT)
                    - CENT_W'(dc_offset_reg);
        centred_abs = centred[CENT_W-1] ? (CENT_W'(0) - centred) : centred;
        abs_low     = centred_abs[MAG_W-1:0];
        mag_next    = (abs_low > MAG_W'(noise_floor_reg))
                    ? (abs_low - MAG_W'(noise_floor_reg)) : '0;
    end

    // 7/8 level smoothing
    assign level_sum  = LSUM_W'(level_reg) * LSUM_W'(alm_pkg::LEVEL_KEEP)
                      + LSUM_W'(mag_reg);
    assign level_next = level_sum[LSUM_W-1:alm_pkg::LEVEL_SHIFT];

    // Scale operands; a level at or below the minimum gives a zero numerator
    assign level_ext = AVG_W'(level_reg);
    assign diff_full = (level_ext > min_avg_reg) ? (level_ext - min_avg_reg) : '0;
    assign span      = max_avg_reg - min_avg_reg;

    // Height clip: below two first, then above top_offset
    always_comb
    begin
        height_raw = span_pos_reg ? scale.quot : NUM_W'(top_offset_reg);
        priority if (height_raw < NUM_W'(alm_pkg::MIN_HEIGHT))
        begin
            height_next = CFG_W'(alm_pkg::MIN_HEIGHT);
        end
        else if (height_raw > NUM_W'(top_offset_reg))
        begin
            height_next = top_offset_reg;
        end
        else
        begin
            height_next = height_raw[CFG_W-1:0];
        end
    end

    // Keep the tracked max at least top_offset above the min
    assign scan_span = scan.mx - scan.mn;
    assign mx_adj    = (scan_span < MAG_W'(top_offset_reg))
                     ? (AVG_W'(scan.mn) + AVG_W'(top_offset_reg))
                     : AVG_W'(scan.mx);

    // Peak dot raise, then the fall step
    always_comb
    begin
        peak_up   = (height_reg > peak_reg) ? height_reg : peak_reg;
        fall_inc  = fall_cnt_reg + CFG_W'(1);
        fall_drop = (fall_inc >= fall_rate_reg);
        if (fall_drop)
        begin
            peak_next     = (peak_up != '0) ? (peak_up - CFG_W'(1)) : '0;
            fall_cnt_next = '0;
        end
        else
        begin
            peak_next     = peak_up;
            fall_cnt_next = fall_inc;
        end
    end

    // 63/64 bound smoothing
    assign min_sum      = BSUM_W'(min_avg_reg) * BSUM_W'(alm_pkg::BOUND_KEEP)
                        + BSUM_W'(mn_hold_reg);
    assign max_sum      = BSUM_W'(max_avg_reg) * BSUM_W'(alm_pkg::BOUND_KEEP)
                        + BSUM_W'(mx_hold_reg);
    assign min_avg_next = min_sum[BSUM_W-1:alm_pkg::BOUND_SHIFT];
    assign max_avg_next = max_sum[BSUM_W-1:alm_pkg::BOUND_SHIFT];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (calc_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set by a finished sample, cleared by a transfer
    always_comb
    begin
        priority if (fin_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            level_reg     <= alm_pkg::LEVEL_RST;
            min_avg_reg   <= alm_pkg::MIN_AVG_RST;
            max_avg_reg   <= alm_pkg::MAX_AVG_RST;
            peak_reg      <= '0;
            fall_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_LEVEL)
            begin
                level_reg <= level_next;
            end
            if (fin_fire)
            begin
                min_avg_reg  <= min_avg_next;
                max_avg_reg  <= max_avg_next;
                peak_reg     <= peak_next;
                fall_cnt_reg <= fall_cnt_next;
            end
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_offset_reg   <= alm_pkg::DC_OFFSET_RST;
            noise_floor_reg <= alm_pkg::NOISE_FLOOR_RST;
            top_offset_reg  <= alm_pkg::TOP_OFFSET_RST;
            led_count_reg   <= alm_pkg::LED_COUNT_RST;
            fall_rate_reg   <= alm_pkg::FALL_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                alm_pkg::REG_DC_OFFSET:   dc_offset_reg   <= cfg_data;
                alm_pkg::REG_NOISE_FLOOR: noise_floor_reg <= cfg_data;
                alm_pkg::REG_TOP_OFFSET:  top_offset_reg  <= cfg_data;
                alm_pkg::REG_LED_COUNT:   led_count_reg   <= cfg_data;
                alm_pkg::REG_FALL_RATE:   fall_rate_reg   <= cfg_data;
                default:
                begin
                    dc_offset_reg <= dc_offset_reg;
                end
            endcase
        end
    end

    // Per-sample datapath and output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= mic_sample;
        end
        if (state_reg == ST_MAG)
        begin
            mag_reg <= mag_next;
        end
        if (state_reg == ST_START)
        begin
            span_pos_reg <= (max_avg_reg > min_avg_reg);
        end
        if ((state_reg == ST_CALC) && calc_done)
        begin
            height_reg  <= height_next;
            mn_hold_reg <= scan.mn;
            mx_hold_reg <= mx_adj;
        end
        if (fin_fire)
        begin
            bar_height_reg     <= height_reg;
            peak_position_reg  <= peak_up;
            peak_visible_reg   <= (peak_up != '0) && (peak_up < led_count_reg);
            smoothed_level_reg <= level_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign bar_height     = bar_height_reg;
    assign peak_position  = peak_position_reg;
    assign peak_visible   = peak_visible_reg;
    assign smoothed_level = smoothed_level_reg;

endmodule
